@@ sv/cps_pkg.sv @@
package cps_pkg;

  // token kind codes
  localparam logic [1:0] KIND_ELEM  = 2'd0;
  localparam logic [1:0] KIND_OPEN  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  // element and image width
  localparam int unsigned ElemW = 4;

  // input transaction
  typedef struct packed {
    logic [1:0]       token_kind;
    logic [ElemW-1:0] element;
    logic             last_token;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [ElemW-1:0] element_index;
    logic [ElemW-1:0] image;
    logic             image_empty;
    logic             last;
  } out_t;

  // one table entry or carry: value plus full flag
  typedef struct packed {
    logic             full;
    logic [ElemW-1:0] val;
  } entry_t;

endpackage

@@ sv/cycle_product_single_pass.sv @@
// tokens: one transaction per cycle, two-stage read-modify-write through the table memory
// readout: starts after the last token is accepted, each result a memory read then the
//   output register, no new read while one is pending or the output is held;
//   min(NUM_ELEMENTS,16) results; input stalls until the final one
// reset: table reads as identity through per-entry written flags, carry empty, no target;
//   the same state is restored at the end of each readout, no clearing pass
module cycle_product_single_pass #(
  parameter int unsigned NUM_ELEMENTS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cps_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cps_pkg::out_t out_data_o
);

  localparam int unsigned Depth = (NUM_ELEMENTS < 16) ? NUM_ELEMENTS : 16;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [4:0]  DepthW = 5'(Depth);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;

  // table port signals
  logic                  tbl_rd_en;
  logic [AddrW-1:0]      tbl_rd_addr;
  cps_pkg::entry_t       tbl_rd_data;
  logic                  tbl_wr_en;
  logic [AddrW-1:0]      tbl_wr_addr;
  cps_pkg::entry_t       tbl_wr_data;
  logic                  tbl_clr;

  // token stage registers
  logic                  s2_valid_q;
  cps_pkg::in_t          s2_tok_q;
  logic                  s2_in_range;

  cps_pkg::entry_t       carry_q, carry_d;
  logic [AddrW-1:0]      tgt_idx_q, tgt_idx_d;
  logic                  tgt_vld_q, tgt_vld_d;

  // readout registers
  logic [AddrW-1:0]      rd_idx_q, rd_idx_d;
  logic                  pend_q, pend_d;
  logic [AddrW-1:0]      pend_idx_q;
  logic                  rd_issue;

  logic                  out_valid_q, out_valid_d;
  cps_pkg::out_t         out_data_q, out_data_d;

  logic                  in_accept;

  assign in_ready_o  = (state_q == ST_RUN);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  cps_table #(
    .Depth(Depth)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (tbl_rd_en),
    .rd_addr_i(tbl_rd_addr),
    .rd_data_o(tbl_rd_data),
    .wr_en_i  (tbl_wr_en),
    .wr_addr_i(tbl_wr_addr),
    .wr_data_i(tbl_wr_data),
    .clr_i    (tbl_clr)
  );

  // read issue: token element or readout index
  assign rd_issue = (state_q == ST_READ) && !pend_q && (!out_valid_q || out_ready_i);
  assign tbl_rd_en   = in_accept || rd_issue;
  assign tbl_rd_addr = (state_q == ST_READ) ? rd_idx_q : in_data_i.element[AddrW-1:0];

  // token stage: modify and write back
  assign s2_in_range = ({1'b0, s2_tok_q.element} < DepthW);

  always_comb begin
    carry_d     = carry_q;
    tgt_idx_d   = tgt_idx_q;
    tgt_vld_d   = tgt_vld_q;
    tbl_wr_en   = 1'b0;
    tbl_wr_addr = s2_tok_q.element[AddrW-1:0];
    tbl_wr_data = carry_q;
    if (s2_valid_q) begin
      case (s2_tok_q.token_kind)
        cps_pkg::KIND_CLOSE: begin
          carry_d = '0;
        end
        cps_pkg::KIND_OPEN: begin
          if (tgt_vld_q) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = tgt_idx_q;
          end
        end
        cps_pkg::KIND_ELEM: begin
          if (s2_in_range) begin
            tbl_wr_en = 1'b1;
            carry_d   = tbl_rd_data;
            if (!carry_q.full) begin
              tgt_idx_d = s2_tok_q.element[AddrW-1:0];
              tgt_vld_d = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
      // state returns to reset after the last token
      if (s2_tok_q.last_token) begin
        carry_d   = '0;
        tgt_idx_d = '0;
        tgt_vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s2_tok_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      carry_q    <= '0;
      tgt_idx_q  <= '0;
      tgt_vld_q  <= 1'b0;
    end else begin
      s2_valid_q <= in_accept;
      carry_q    <= carry_d;
      tgt_idx_q  <= tgt_idx_d;
      tgt_vld_q  <= tgt_vld_d;
    end
  end

  // readout sequencing
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    pend_d   = 1'b0;
    tbl_clr  = 1'b0;
    case (state_q)
      ST_RUN: begin
        rd_idx_d = '0;
        if (in_accept && in_data_i.last_token) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_issue) begin
          pend_d   = 1'b1;
          rd_idx_d = (rd_idx_q == LastIdx) ? '0 : rd_idx_q + 1'b1;
        end
        if (pend_q && (pend_idx_q == LastIdx)) begin
          tbl_clr = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      pend_idx_q <= rd_idx_q;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pend_q) begin
      out_valid_d              = 1'b1;
      out_data_d.element_index = cps_pkg::ElemW'(pend_idx_q);
      out_data_d.image         = tbl_rd_data.full ? tbl_rd_data.val : '0;
      out_data_d.image_empty   = !tbl_rd_data.full;
      out_data_d.last          = (pend_idx_q == LastIdx);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ sv/cps_table.sv @@
module cps_table #(
  parameter int unsigned Depth = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      rd_en_i,
  input  logic [$clog2(Depth)-1:0]  rd_addr_i,
  output cps_pkg::entry_t           rd_data_o,
  input  logic                      wr_en_i,
  input  logic [$clog2(Depth)-1:0]  wr_addr_i,
  input  cps_pkg::entry_t           wr_data_i,
  input  logic                      clr_i
);

  localparam int unsigned AddrW = $clog2(Depth);

  cps_pkg::entry_t mem_q [Depth];
  cps_pkg::entry_t rd_q;
  cps_pkg::entry_t fwd_data_q;
  logic            fwd_hit_q;
  logic [AddrW-1:0] rd_addr_q;
  logic [Depth-1:0] vld_q;

  // memory write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // memory read port with write forwarding for same-cycle access
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      rd_addr_q  <= rd_addr_i;
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_hit_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  // written flags, an unwritten entry reads as identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // resolve read data
  always_comb begin
    if (!vld_q[rd_addr_q]) begin
      rd_data_o.full = 1'b1;
      rd_data_o.val  = cps_pkg::ElemW'(rd_addr_q);
    end else if (fwd_hit_q) begin
      rd_data_o = fwd_data_q;
    end else begin
      rd_data_o = rd_q;
    end
  end

endmodule

@@ dv/cps_product_checker.sv @@
`timescale 1ns / 1ps

module cps_product_checker #(
  parameter int unsigned NUM_ELEMENTS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  cps_pkg::in_t   in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  cps_pkg::out_t  out_data_i,
  output int             errors_o,
  output int             pending_o,
  output int             tokens_o,
  output int             readouts_o,
  output int             results_o
);

  localparam int unsigned ReadCount = (NUM_ELEMENTS < 16) ? NUM_ELEMENTS : 16;

  // predicted product state
  cps_pkg::entry_t img_map [NUM_ELEMENTS];
  cps_pkg::entry_t carry;
  logic            target_valid;
  int unsigned     target_idx;

  // readout pairs still owed by the block
  cps_pkg::out_t   readout_q [$];

  int mismatch_cnt = 0;
  int pending_cnt  = 0;
  int token_cnt    = 0;
  int readout_cnt  = 0;
  int result_cnt   = 0;

  assign errors_o   = mismatch_cnt;
  assign pending_o  = pending_cnt;
  assign tokens_o   = token_cnt;
  assign readouts_o = readout_cnt;
  assign results_o  = result_cnt;

  // identity map, empty carry, no open target
  task automatic clear_product();
    for (int i = 0; i < NUM_ELEMENTS; i++) begin
      img_map[i].full = 1'b1;
      img_map[i].val  = i[cps_pkg::ElemW-1:0];
    end
    carry        = '0;
    target_valid = 1'b0;
    target_idx   = 0;
  endtask

  // one token of the right-to-left pass, readout on the leftmost one
  task automatic apply_token(input cps_pkg::in_t t);
    cps_pkg::entry_t held;
    cps_pkg::out_t   pair;
    case (t.token_kind)
      cps_pkg::KIND_CLOSE: begin
        carry = '0;
      end
      cps_pkg::KIND_OPEN: begin
        if (target_valid) img_map[target_idx] = carry;
      end
      cps_pkg::KIND_ELEM: begin
        if (t.element < NUM_ELEMENTS) begin
          held               = img_map[t.element];
          img_map[t.element] = carry;
          carry              = held;
          if (!img_map[t.element].full) begin
            target_idx   = t.element;
            target_valid = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (t.last_token) begin
      for (int i = 0; i < ReadCount; i++) begin
        pair.element_index = i[cps_pkg::ElemW-1:0];
        pair.image         = img_map[i].full ? img_map[i].val : '0;
        pair.image_empty   = !img_map[i].full;
        pair.last          = (i == ReadCount - 1);
        readout_q = {readout_q, pair};
      end
      readout_cnt++;
      clear_product();
    end
  endtask

  task automatic field_check(input string name, input logic [3:0] want,
                             input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // compare one readout transaction with the oldest owed pair
  task automatic check_pair(input cps_pkg::out_t got);
    cps_pkg::out_t want;
    if (readout_q.size() == 0) begin
      $display("%0t: result with none expected, got index %0d image %0d empty %0b last %0b",
               $time, got.element_index, got.image, got.image_empty, got.last);
      mismatch_cnt++;
    end else begin
      want = readout_q.pop_front();
      field_check("element_index", want.element_index, got.element_index);
      field_check("image", want.image, got.image);
      field_check("image_empty", {3'b0, want.image_empty}, {3'b0, got.image_empty});
      field_check("last", {3'b0, want.last}, {3'b0, got.last});
    end
    result_cnt++;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_product();
      readout_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_pair(out_data_i);
      if (in_valid_i && in_ready_i) begin
        apply_token(in_data_i);
        token_cnt++;
      end
    end
    pending_cnt = readout_q.size();
  end

endmodule

@@ dv/cycle_product_single_pass_tb.sv @@
`timescale 1ns / 1ps

module cycle_product_single_pass_tb;

  localparam int unsigned NumElements = 16;
  localparam int PhaseTokens = 45;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 200;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          tok_valid = 1'b0;
  logic          tok_ready;
  cps_pkg::in_t  tok       = '0;
  logic          res_valid;
  logic          res_ready = 1'b0;
  cps_pkg::out_t res;

  int errors, pending, tokens, readouts, results;

  rx_mode_e     rx_mode    = RX_OPEN;
  bit           tx_gaps    = 1'b0;
  int           burst_left = 0;
  int           hold_req   = 0;
  int           hold_ack   = 0;
  int           hold_left  = 0;
  int           rx_tick    = 0;
  int           cycles     = 0;
  cps_pkg::in_t tok_seq [$];

  cycle_product_single_pass #(.NUM_ELEMENTS(NumElements)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tok_valid),
    .in_ready_o  (tok_ready),
    .in_data_i   (tok),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res)
  );

  cps_product_checker #(.NUM_ELEMENTS(NumElements)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tok_valid),
    .in_ready_i  (tok_ready),
    .in_data_i   (tok),
    .out_valid_i (res_valid),
    .out_ready_i (res_ready),
    .out_data_i  (res),
    .errors_o    (errors),
    .pending_o   (pending),
    .tokens_o    (tokens),
    .readouts_o  (readouts),
    .results_o   (results)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("cycle_product_single_pass: mismatch");
      $finish;
    end
  end

  // receiver: long hold-off on request, else stall pattern of the phase
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_COIN:     res_ready <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY:   res_ready <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: res_ready <= ((rx_tick % 7) < 3);
        default:     res_ready <= 1'b1;
      endcase
    end
  end

  function automatic cps_pkg::in_t mk_token(input logic [1:0] kind, input logic [3:0] elem,
                                            input logic lst);
    cps_pkg::in_t t;
    t.token_kind = kind;
    t.element    = elem;
    t.last_token = lst;
    return t;
  endfunction

  // append one token to the sequence
  task automatic add_token(input cps_pkg::in_t t);
    tok_seq = {tok_seq, t};
  endtask

  // offer one token, with bursts and gaps when enabled; returns at the falling edge
  task automatic send_token(input cps_pkg::in_t t);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        tok_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    tok_valid <= 1'b1;
    tok       <= t;
    @(posedge clk);
    while (!tok_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_seq();
    foreach (tok_seq[k]) send_token(tok_seq[k]);
  endtask

  // sender pauses until every readout pair has come back
  task automatic drain();
    tok_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // random product of cycles, now and then broken, or a run of noise tokens
  task automatic build_product();
    int n_cyc, len, n_noise;
    tok_seq.delete();
    if ($urandom_range(0, 9) < 8) begin
      n_cyc = $urandom_range(1, 4);
      for (int c = 0; c < n_cyc; c++) begin
        len = $urandom_range(1, 6);
        add_token(mk_token(cps_pkg::KIND_CLOSE, 4'($urandom), 1'b0));
        for (int e = 0; e < len; e++)
          add_token(mk_token(cps_pkg::KIND_ELEM, 4'($urandom_range(0, 15)), 1'b0));
        // a cycle missing its open bracket leaves entries empty
        if ($urandom_range(0, 7) != 0)
          add_token(mk_token(cps_pkg::KIND_OPEN, 4'($urandom), 1'b0));
      end
    end else begin
      n_noise = $urandom_range(1, 8);
      for (int k = 0; k < n_noise; k++)
        add_token(mk_token(2'($urandom_range(0, 3)), 4'($urandom), 1'b0));
    end
    // mostly end the product here, sometimes let it run into the next one
    if ($urandom_range(0, 5) != 0) begin
      tok_seq[tok_seq.size() - 1].last_token = 1'b1;
    end
  endtask

  initial begin
    int sent;

    // hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cases, no idling
    tok_seq.delete();
    // open with no target, then the spare kind
    add_token(mk_token(cps_pkg::KIND_OPEN, 4'd0, 1'b0));
    add_token(mk_token(KIND_SPARE, 4'd15, 1'b0));
    // cycle (0 15) with the last flag on its open bracket
    add_token(mk_token(cps_pkg::KIND_CLOSE, 4'd0, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd15, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd0, 1'b0));
    add_token(mk_token(cps_pkg::KIND_OPEN, 4'd0, 1'b1));
    // unbracketed elements leave an empty entry, readout on the spare kind
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd3, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd5, 1'b0));
    add_token(mk_token(KIND_SPARE, 4'd0, 1'b1));
    // (1 2 3)(2 4), read right to left
    add_token(mk_token(cps_pkg::KIND_CLOSE, 4'd15, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd4, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd2, 1'b0));
    add_token(mk_token(cps_pkg::KIND_OPEN, 4'd15, 1'b0));
    add_token(mk_token(cps_pkg::KIND_CLOSE, 4'd0, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd3, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd2, 1'b0));
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd1, 1'b0));
    add_token(mk_token(cps_pkg::KIND_OPEN, 4'd0, 1'b1));
    // lone element that is also the last token
    add_token(mk_token(cps_pkg::KIND_ELEM, 4'd7, 1'b1));
    // close as the last token on an untouched map
    add_token(mk_token(cps_pkg::KIND_CLOSE, 4'd10, 1'b1));
    send_seq();
    drain();

    // random phases, all but the first with their own idling
    for (int phase = 0; phase < 4; phase++) begin
      tx_gaps = (phase != 0);
      rx_mode = rx_mode_e'(phase);
      if (phase == 2) hold_req++;
      sent = 0;
      while (sent < PhaseTokens) begin
        build_product();
        send_seq();
        sent += tok_seq.size();
      end
      drain();
    end

    // flush any open product and wait out the readout
    rx_mode = RX_OPEN;
    send_token(mk_token(cps_pkg::KIND_CLOSE, 4'd0, 1'b1));
    drain();
    repeat (20) @(negedge clk);

    $display("ran %0d tokens through %0d readouts, %0d pairs compared",
             tokens, readouts, results);
    $display("with bursty input, four receiver patterns, a long hold-off and drain pauses");
    if (errors == 0 && pending == 0) begin
      $display("cycle_product_single_pass: match");
    end else begin
      $display("cycle_product_single_pass: mismatch");
    end
    $finish;
  end

endmodule
